FILE: sv/tool_and_sleep_window_qualifier_defines.svh
// Assertion macros shared by the tool and sleep window qualifier RTL.
`ifndef TOOL_AND_SLEEP_WINDOW_QUALIFIER_DEFINES_SVH
`define TOOL_AND_SLEEP_WINDOW_QUALIFIER_DEFINES_SVH

// Same-cycle implication, checked on clk_i and held off during reset.
`define TSWQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and held off during reset.
`define TSWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tswq_pkg.sv
// Package with types, codes and constants of the tool and sleep window qualifier.
`timescale 1ns / 1ps
`default_nettype none
package tswq_pkg;

  // Counter and register widths.
  localparam int unsigned COUNT_BITS_DEF = 10;
  localparam int unsigned CFG_W          = 10;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned NUM_QUAL       = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUCCESS_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE2_MODE    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]  WINDOW_LENGTH_RST = 10'd10;
  localparam logic [CFG_W-1:0]  SUCCESS_COUNT_RST = 10'd8;
  localparam logic [CFG_W-1:0]  FAIL_COUNT_RST    = 10'd2;
  localparam logic [CFG_W-1:0]  HALF_COUNT_RST    = 10'd5;

  // Type 2 decision modes; the unused code behaves as the level check off.
  localparam logic [MODE_W-1:0] T2_MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] T2_MODE_BAND = 2'd1;
  localparam logic [MODE_W-1:0] T2_MODE_LOW  = 2'd2;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Bit positions of the enables and the update flags.
  localparam int unsigned EN_PRESENCE = 0;
  localparam int unsigned EN_TYPE1    = 1;
  localparam int unsigned EN_TYPE2    = 2;
  localparam int unsigned EN_SLEEP    = 3;

  // Tool type codes.
  localparam logic [1:0] TYPE_NONE  = 2'd0;
  localparam logic [1:0] TYPE_SMALL = 2'd1;
  localparam logic [1:0] TYPE_LARGE = 2'd2;

  // Sleep status codes.
  localparam logic [1:0] SLEEP_ERROR   = 2'd0;
  localparam logic [1:0] SLEEP_IN_BASE = 2'd1;
  localparam logic [1:0] SLEEP_ASLEEP  = 2'd2;
  localparam logic [1:0] SLEEP_WORKING = 2'd3;

  // Kept sleep code bits and the codes that map to a state.
  localparam logic [7:0] SC_NONE      = 8'h00;
  localparam logic [7:0] SC_BASE_LOW  = 8'h08;
  localparam logic [7:0] SC_BASE_HIGH = 8'h01;
  localparam logic [7:0] SC_TOOL_LOW  = 8'h80;
  localparam logic [7:0] SC_TOOL_HIGH = 8'h10;
  localparam logic [7:0] SC_ERROR     = 8'h88;
  localparam logic [7:0] SC_BASE_TLOW = 8'h81;
  localparam logic [7:0] SC_SLP_BLOW  = 8'h18;
  localparam logic [7:0] SC_WORKING   = 8'h11;

  // One input beat as held in the input register.
  typedef struct packed {
    logic                req_type;
    logic [NUM_QUAL-1:0] check_enables;
    logic                heating;
    logic                presence_pin;
    logic                type1_pin;
    logic                type2_pin;
    logic                handle_pin;
    logic                tip_pin;
  } in_item_t;

endpackage
`default_nettype wire

FILE: sv/tool_and_sleep_window_qualifier.sv
// Tool and sleep window qualifier: four windowed pin qualifiers behind valid/ready channels.
`timescale 1ns / 1ps
`default_nettype none
`include "tool_and_sleep_window_qualifier_defines.svh"
// Takes one beat per clock cycle while the result channel keeps up, and returns one
// result beat for each input beat, by way of an input register and then the qualifier
// state, which doubles as the result register. Each beat either samples the five pins
// into the presence, type 1, type 2 and sleep qualifiers or clears them all. The state
// is only updated when the result register is free or being taken, so back pressure on
// the result channel stalls the input register and then the input channel. The
// configuration port is always ready and must only be written while the block is idle.
// There is no clearing pass after reset.
module tool_and_sleep_window_qualifier #(
  parameter int unsigned COUNT_BITS = tswq_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write channel.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tswq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [tswq_pkg::CFG_W-1:0]     cfg_data_i,
  // Input channel.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           req_type_i,
  input  wire logic [tswq_pkg::NUM_QUAL-1:0]  check_enables_i,
  input  wire logic                           heating_i,
  input  wire logic                           presence_pin_i,
  input  wire logic                           type1_pin_i,
  input  wire logic                           type2_pin_i,
  input  wire logic                           handle_pin_i,
  input  wire logic                           tip_pin_i,
  // Result channel.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                tool_present_o,
  output logic [1:0]                          first_type_o,
  output logic [1:0]                          second_type_o,
  output logic [1:0]                          sleep_status_o,
  output logic [tswq_pkg::NUM_QUAL-1:0]       window_done_flags_o
);
  import tswq_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CntZero = '0;

  // Configuration registers.
  logic [CFG_W-1:0]  window_length_q, success_count_q, fail_count_q, half_count_q;
  logic [MODE_W-1:0] type2_mode_q;

  // Pipeline control.
  in_item_t s1_q;
  logic     s1_valid_q;
  logic     out_valid_q;
  logic     s1_adv;
  logic     s1_clear;

  // Qualifier counters.
  logic [COUNT_BITS-1:0] pres_lo_q, pres_hi_q, pres_win_q;
  logic [COUNT_BITS-1:0] pres_lo_d, pres_hi_d, pres_win_d;
  logic [COUNT_BITS-1:0] t1_lo_q, t1_hi_q, t1_win_q;
  logic [COUNT_BITS-1:0] t1_lo_d, t1_hi_d, t1_win_d;
  logic [COUNT_BITS-1:0] t2_lo_q, t2_hi_q, t2_win_q;
  logic [COUNT_BITS-1:0] t2_lo_d, t2_hi_d, t2_win_d;
  logic [COUNT_BITS-1:0] slp_hlo_q, slp_hhi_q, slp_tlo_q, slp_thi_q, slp_win_q;
  logic [COUNT_BITS-1:0] slp_hlo_d, slp_hhi_d, slp_tlo_d, slp_thi_d, slp_win_d;

  // Decisions, flags and the kept sleep code; the decisions and flags also drive the result beat.
  logic                present_q, present_d;
  logic [1:0]          first_q, first_d;
  logic [1:0]          second_q, second_d;
  logic [1:0]          sleep_q, sleep_d;
  logic [NUM_QUAL-1:0] flags_q, flags_d;
  logic [7:0]          sleep_code_q, sleep_code_d;
  logic                t2_band_lo, t2_band_hi;

  // Saturating increment.
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == CntMax) ? v : v + COUNT_BITS'(1);
  endfunction

  // Counter above a threshold register.
  function automatic logic cnt_gt(input logic [COUNT_BITS-1:0] c,
                                  input logic [CFG_W-1:0] t);
    cnt_gt = CmpW'(c) > CmpW'(t);
  endfunction

  // Counter below a threshold register.
  function automatic logic cnt_lt(input logic [COUNT_BITS-1:0] c,
                                  input logic [CFG_W-1:0] t);
    cnt_lt = CmpW'(c) < CmpW'(t);
  endfunction

  // Window end test; a saturated window count always closes.
  function automatic logic win_closes(input logic [COUNT_BITS-1:0] n,
                                      input logic [CFG_W-1:0] len,
                                      input logic incl);
    logic at_len;
    at_len = incl ? (CmpW'(n) >= CmpW'(len)) : (CmpW'(n) > CmpW'(len));
    win_closes = (n == CntMax) || at_len;
  endfunction

  // Configuration writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WINDOW_LENGTH_RST;
      success_count_q <= SUCCESS_COUNT_RST;
      fail_count_q    <= FAIL_COUNT_RST;
      half_count_q    <= HALF_COUNT_RST;
      type2_mode_q    <= T2_MODE_BAND;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LENGTH: window_length_q <= cfg_data_i;
        CFG_SUCCESS_COUNT: success_count_q <= cfg_data_i;
        CFG_FAIL_COUNT:    fail_count_q    <= cfg_data_i;
        CFG_HALF_COUNT:    half_count_q    <= cfg_data_i;
        CFG_TYPE2_MODE:    type2_mode_q    <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result slot is free or being taken.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_clear   = (s1_q.req_type == REQ_CLEAR);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q.req_type      <= req_type_i;
      s1_q.check_enables <= check_enables_i;
      s1_q.heating       <= heating_i;
      s1_q.presence_pin  <= presence_pin_i;
      s1_q.type1_pin     <= type1_pin_i;
      s1_q.type2_pin     <= type2_pin_i;
      s1_q.handle_pin    <= handle_pin_i;
      s1_q.tip_pin       <= tip_pin_i;
    end
  end

  // Next state of all four qualifiers for the beat in the input register.
  always_comb begin
    pres_lo_d    = pres_lo_q;
    pres_hi_d    = pres_hi_q;
    pres_win_d   = pres_win_q;
    t1_lo_d      = t1_lo_q;
    t1_hi_d      = t1_hi_q;
    t1_win_d     = t1_win_q;
    t2_lo_d      = t2_lo_q;
    t2_hi_d      = t2_hi_q;
    t2_win_d     = t2_win_q;
    slp_hlo_d    = slp_hlo_q;
    slp_hhi_d    = slp_hhi_q;
    slp_tlo_d    = slp_tlo_q;
    slp_thi_d    = slp_thi_q;
    slp_win_d    = slp_win_q;
    present_d    = present_q;
    first_d      = first_q;
    second_d     = second_q;
    sleep_d      = sleep_q;
    flags_d      = flags_q;
    sleep_code_d = sleep_code_q;
    t2_band_lo   = 1'b0;
    t2_band_hi   = 1'b0;

    if (s1_adv && s1_clear) begin
      // Clear request: everything but the kept sleep code goes to zero.
      pres_lo_d  = CntZero;
      pres_hi_d  = CntZero;
      pres_win_d = CntZero;
      t1_lo_d    = CntZero;
      t1_hi_d    = CntZero;
      t1_win_d   = CntZero;
      t2_lo_d    = CntZero;
      t2_hi_d    = CntZero;
      t2_win_d   = CntZero;
      slp_hlo_d  = CntZero;
      slp_hhi_d  = CntZero;
      slp_tlo_d  = CntZero;
      slp_thi_d  = CntZero;
      slp_win_d  = CntZero;
      present_d  = 1'b0;
      first_d    = TYPE_NONE;
      second_d   = TYPE_NONE;
      sleep_d    = SLEEP_ERROR;
      flags_d    = '0;
    end else if (s1_adv) begin
      // Presence qualifier, frozen while heating.
      if (!s1_q.check_enables[EN_PRESENCE]) begin
        pres_lo_d  = CntZero;
        pres_hi_d  = CntZero;
        pres_win_d = CntZero;
        flags_d[EN_PRESENCE] = 1'b0;
      end else if (!s1_q.heating) begin
        pres_lo_d  = s1_q.presence_pin ? pres_lo_q : sat_inc(pres_lo_q);
        pres_hi_d  = s1_q.presence_pin ? sat_inc(pres_hi_q) : pres_hi_q;
        pres_win_d = sat_inc(pres_win_q);
        if (win_closes(pres_win_d, window_length_q, 1'b0)) begin
          flags_d[EN_PRESENCE] = 1'b1;
          present_d = cnt_gt(pres_lo_d, success_count_q) &&
                      !cnt_gt(pres_hi_d, success_count_q);
          pres_lo_d  = CntZero;
          pres_hi_d  = CntZero;
          pres_win_d = CntZero;
        end
      end

      // Type 1 qualifier.
      if (!s1_q.check_enables[EN_TYPE1]) begin
        t1_lo_d  = CntZero;
        t1_hi_d  = CntZero;
        t1_win_d = CntZero;
        flags_d[EN_TYPE1] = 1'b0;
      end else begin
        t1_lo_d  = s1_q.type1_pin ? t1_lo_q : sat_inc(t1_lo_q);
        t1_hi_d  = s1_q.type1_pin ? sat_inc(t1_hi_q) : t1_hi_q;
        t1_win_d = sat_inc(t1_win_q);
        if (win_closes(t1_win_d, window_length_q, 1'b0)) begin
          flags_d[EN_TYPE1] = 1'b1;
          if (cnt_gt(t1_hi_d, success_count_q)) begin
            first_d = TYPE_LARGE;
          end else if (cnt_gt(t1_lo_d, success_count_q)) begin
            first_d = TYPE_SMALL;
          end
          t1_lo_d  = CntZero;
          t1_hi_d  = CntZero;
          t1_win_d = CntZero;
        end
      end

      // Type 2 qualifier; its window closes on reaching the length.
      if (!s1_q.check_enables[EN_TYPE2]) begin
        t2_lo_d  = CntZero;
        t2_hi_d  = CntZero;
        t2_win_d = CntZero;
        flags_d[EN_TYPE2] = 1'b0;
      end else begin
        t2_lo_d  = s1_q.type2_pin ? t2_lo_q : sat_inc(t2_lo_q);
        t2_hi_d  = s1_q.type2_pin ? sat_inc(t2_hi_q) : t2_hi_q;
        t2_win_d = sat_inc(t2_win_q);
        if (win_closes(t2_win_d, window_length_q, 1'b1)) begin
          flags_d[EN_TYPE2] = 1'b1;
          // Square-wave band test on the counts of the window that just closed.
          t2_band_lo = cnt_gt(t2_lo_d, fail_count_q) && cnt_lt(t2_lo_d, success_count_q);
          t2_band_hi = cnt_gt(t2_hi_d, fail_count_q) && cnt_lt(t2_hi_d, success_count_q);
          if (cnt_gt(t2_hi_d, success_count_q)) begin
            second_d = TYPE_SMALL;
          end else begin
            case (type2_mode_q)
              T2_MODE_BAND: begin
                if (t2_band_lo || t2_band_hi) begin
                  second_d = TYPE_LARGE;
                end
              end
              T2_MODE_LOW: begin
                if (cnt_gt(t2_lo_d, half_count_q)) begin
                  second_d = TYPE_LARGE;
                end
              end
              default: ;
            endcase
          end
          t2_lo_d  = CntZero;
          t2_hi_d  = CntZero;
          t2_win_d = CntZero;
        end
      end

      // Sleep qualifier, frozen while heating.
      if (!s1_q.check_enables[EN_SLEEP]) begin
        slp_hlo_d = CntZero;
        slp_hhi_d = CntZero;
        slp_tlo_d = CntZero;
        slp_thi_d = CntZero;
        slp_win_d = CntZero;
        flags_d[EN_SLEEP] = 1'b0;
      end else if (!s1_q.heating) begin
        slp_hlo_d = s1_q.handle_pin ? slp_hlo_q : sat_inc(slp_hlo_q);
        slp_hhi_d = s1_q.handle_pin ? sat_inc(slp_hhi_q) : slp_hhi_q;
        slp_tlo_d = s1_q.tip_pin ? slp_tlo_q : sat_inc(slp_tlo_q);
        slp_thi_d = s1_q.tip_pin ? sat_inc(slp_thi_q) : slp_thi_q;
        slp_win_d = sat_inc(slp_win_q);
        if (win_closes(slp_win_d, window_length_q, 1'b0)) begin
          flags_d[EN_SLEEP] = 1'b1;
          // Base part replaces the kept code, or leaves it as it is.
          if (cnt_gt(slp_hlo_d, success_count_q)) begin
            sleep_code_d = SC_BASE_LOW;
          end else if (cnt_lt(slp_hhi_d, half_count_q)) begin
            sleep_code_d = SC_NONE;
          end else if (cnt_gt(slp_hhi_d, success_count_q)) begin
            sleep_code_d = SC_BASE_HIGH;
          end
          // Tool part ORs its bit into the code.
          if (cnt_gt(slp_tlo_d, success_count_q)) begin
            sleep_code_d = sleep_code_d | SC_TOOL_LOW;
          end else if (!cnt_lt(slp_thi_d, half_count_q) &&
                       cnt_gt(slp_thi_d, success_count_q)) begin
            sleep_code_d = sleep_code_d | SC_TOOL_HIGH;
          end
          // Map the code to a state; other codes keep the old state.
          case (sleep_code_d) inside
            SC_ERROR:                  sleep_d = SLEEP_ERROR;
            SC_BASE_HIGH, SC_BASE_TLOW: sleep_d = SLEEP_IN_BASE;
            SC_TOOL_HIGH, SC_SLP_BLOW: sleep_d = SLEEP_ASLEEP;
            SC_WORKING:                sleep_d = SLEEP_WORKING;
            default: ;
          endcase
          slp_hlo_d = CntZero;
          slp_hhi_d = CntZero;
          slp_tlo_d = CntZero;
          slp_thi_d = CntZero;
          slp_win_d = CntZero;
        end
      end
    end
  end

  // Qualifier state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_lo_q    <= CntZero;
      pres_hi_q    <= CntZero;
      pres_win_q   <= CntZero;
      t1_lo_q      <= CntZero;
      t1_hi_q      <= CntZero;
      t1_win_q     <= CntZero;
      t2_lo_q      <= CntZero;
      t2_hi_q      <= CntZero;
      t2_win_q     <= CntZero;
      slp_hlo_q    <= CntZero;
      slp_hhi_q    <= CntZero;
      slp_tlo_q    <= CntZero;
      slp_thi_q    <= CntZero;
      slp_win_q    <= CntZero;
      present_q    <= 1'b0;
      first_q      <= TYPE_NONE;
      second_q     <= TYPE_NONE;
      sleep_q      <= SLEEP_ERROR;
      flags_q      <= '0;
      sleep_code_q <= SC_ERROR;
    end else begin
      pres_lo_q    <= pres_lo_d;
      pres_hi_q    <= pres_hi_d;
      pres_win_q   <= pres_win_d;
      t1_lo_q      <= t1_lo_d;
      t1_hi_q      <= t1_hi_d;
      t1_win_q     <= t1_win_d;
      t2_lo_q      <= t2_lo_d;
      t2_hi_q      <= t2_hi_d;
      t2_win_q     <= t2_win_d;
      slp_hlo_q    <= slp_hlo_d;
      slp_hhi_q    <= slp_hhi_d;
      slp_tlo_q    <= slp_tlo_d;
      slp_thi_q    <= slp_thi_d;
      slp_win_q    <= slp_win_d;
      present_q    <= present_d;
      first_q      <= first_d;
      second_q     <= second_d;
      sleep_q      <= sleep_d;
      flags_q      <= flags_d;
      sleep_code_q <= sleep_code_d;
    end
  end

  // Result beat straight from the decision registers.
  assign out_valid_o         = out_valid_q;
  assign tool_present_o      = present_q;
  assign first_type_o        = first_q;
  assign second_type_o       = second_q;
  assign sleep_status_o      = sleep_q;
  assign window_done_flags_o = flags_q;

  // Assertions.
  `TSWQ_ASSERT_NEXT(a_clear_zeroes, s1_adv && s1_clear,
    !tool_present_o && first_type_o == TYPE_NONE && second_type_o == TYPE_NONE &&
    sleep_status_o == SLEEP_ERROR && window_done_flags_o == '0,
    "clear request did not zero the result")
  `TSWQ_ASSERT_NEXT(a_disabled_flag_low, s1_adv && !s1_clear,
    (window_done_flags_o & ~$past(s1_q.check_enables)) == '0,
    "update flag set for a disabled qualifier")
  `TSWQ_ASSERT_NOW(a_type_codes, 1'b1,
    first_type_o != 2'd3 && second_type_o != 2'd3,
    "tool type holds an unused code")
  `TSWQ_ASSERT_NOW(a_stall_cause, !in_ready_o,
    s1_valid_q && out_valid_o && !out_ready_i,
    "input stalled without a blocked result")

endmodule
`default_nettype wire

FILE: dv/tswq_decision_checker.sv
// Checker that predicts and compares every result beat of the tool and sleep window qualifier.
`timescale 1ns / 1ps
module tswq_decision_checker #(
  parameter int unsigned COUNT_BITS = tswq_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tswq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tswq_pkg::CFG_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           req_type_i,
  input  logic [tswq_pkg::NUM_QUAL-1:0]  check_enables_i,
  input  logic                           heating_i,
  input  logic                           presence_pin_i,
  input  logic                           type1_pin_i,
  input  logic                           type2_pin_i,
  input  logic                           handle_pin_i,
  input  logic                           tip_pin_i,
  // Result channel.
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           tool_present_i,
  input  logic [1:0]                     first_type_i,
  input  logic [1:0]                     second_type_i,
  input  logic [1:0]                     sleep_status_i,
  input  logic [tswq_pkg::NUM_QUAL-1:0]  window_done_flags_i,
  // Status handed to the testbench top.
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import tswq_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic                tool_present;
    logic [1:0]          first_type;
    logic [1:0]          second_type;
    logic [1:0]          sleep_status;
    logic [NUM_QUAL-1:0] done_flags;
  } decision_t;

  // Shadow copy of the configuration registers.
  logic [CFG_W-1:0]  window_len;
  logic [CFG_W-1:0]  success_thr;
  logic [CFG_W-1:0]  fail_thr;
  logic [CFG_W-1:0]  half_thr;
  logic [MODE_W-1:0] t2_mode;

  // Shadow copy of the qualifier counters and decisions.
  count_t pres_lo, pres_hi, pres_win;
  count_t t1_lo, t1_hi, t1_win;
  count_t t2_lo, t2_hi, t2_win;
  count_t base_lo, base_hi, tip_lo, tip_hi, slp_win;
  logic [7:0]          sleep_code;
  logic                dec_present;
  logic [1:0]          dec_first;
  logic [1:0]          dec_second;
  logic [1:0]          dec_sleep;
  logic [NUM_QUAL-1:0] done_flags;

  decision_t   expected_decisions[$];
  int unsigned mismatch_total;

  // Counters stop at their all-ones value.
  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // A window closes past its length, at its length when inclusive, or at saturation.
  function automatic logic window_closes(count_t n, logic inclusive);
    if (n == '1) return 1'b1;
    return inclusive ? (n >= window_len) : (n > window_len);
  endfunction

  function automatic void clear_qualifiers();
    {pres_lo, pres_hi, pres_win} = '0;
    {t1_lo, t1_hi, t1_win}       = '0;
    {t2_lo, t2_hi, t2_win}       = '0;
    {base_lo, base_hi, tip_lo, tip_hi, slp_win} = '0;
    dec_present = 1'b0;
    dec_first   = TYPE_NONE;
    dec_second  = TYPE_NONE;
    dec_sleep   = SLEEP_ERROR;
    done_flags  = '0;
  endfunction

  // Advances the shadow state by one input beat and returns the decisions it shows.
  function automatic decision_t predict_decisions(in_item_t beat);
    decision_t d;
    logic      band_lo;
    logic      band_hi;
    if (beat.req_type == REQ_CLEAR) begin
      clear_qualifiers();
    end else begin
      // Presence qualifier, frozen while heating.
      if (!beat.check_enables[EN_PRESENCE]) begin
        {pres_lo, pres_hi, pres_win} = '0;
        done_flags[EN_PRESENCE] = 1'b0;
      end else if (!beat.heating) begin
        if (beat.presence_pin) pres_hi = sat_inc(pres_hi);
        else                   pres_lo = sat_inc(pres_lo);
        pres_win = sat_inc(pres_win);
        if (window_closes(pres_win, 1'b0)) begin
          done_flags[EN_PRESENCE] = 1'b1;
          dec_present = (pres_lo > success_thr) && !(pres_hi > success_thr);
          {pres_lo, pres_hi, pres_win} = '0;
        end
      end

      // Type qualifier on pin 1.
      if (!beat.check_enables[EN_TYPE1]) begin
        {t1_lo, t1_hi, t1_win} = '0;
        done_flags[EN_TYPE1] = 1'b0;
      end else begin
        if (beat.type1_pin) t1_hi = sat_inc(t1_hi);
        else                t1_lo = sat_inc(t1_lo);
        t1_win = sat_inc(t1_win);
        if (window_closes(t1_win, 1'b0)) begin
          done_flags[EN_TYPE1] = 1'b1;
          if (t1_lo > success_thr) dec_first = TYPE_SMALL;
          if (t1_hi > success_thr) dec_first = TYPE_LARGE;
          {t1_lo, t1_hi, t1_win} = '0;
        end
      end

      // Type qualifier on pin 2; its window closes on reaching the length.
      if (!beat.check_enables[EN_TYPE2]) begin
        {t2_lo, t2_hi, t2_win} = '0;
        done_flags[EN_TYPE2] = 1'b0;
      end else begin
        if (beat.type2_pin) t2_hi = sat_inc(t2_hi);
        else                t2_lo = sat_inc(t2_lo);
        t2_win = sat_inc(t2_win);
        if (window_closes(t2_win, 1'b1)) begin
          done_flags[EN_TYPE2] = 1'b1;
          band_lo = (t2_lo > fail_thr) && (t2_lo < success_thr);
          band_hi = (t2_hi > fail_thr) && (t2_hi < success_thr);
          if (t2_hi > success_thr) begin
            dec_second = TYPE_SMALL;
          end else if (t2_mode == T2_MODE_BAND) begin
            if (band_lo || band_hi) dec_second = TYPE_LARGE;
          end else if (t2_mode == T2_MODE_LOW) begin
            if (t2_lo > half_thr) dec_second = TYPE_LARGE;
          end
          {t2_lo, t2_hi, t2_win} = '0;
        end
      end

      // Sleep qualifier, frozen while heating; it keeps a code across windows.
      if (!beat.check_enables[EN_SLEEP]) begin
        {base_lo, base_hi, tip_lo, tip_hi, slp_win} = '0;
        done_flags[EN_SLEEP] = 1'b0;
      end else if (!beat.heating) begin
        if (beat.handle_pin) base_hi = sat_inc(base_hi);
        else                 base_lo = sat_inc(base_lo);
        if (beat.tip_pin)    tip_hi  = sat_inc(tip_hi);
        else                 tip_lo  = sat_inc(tip_lo);
        slp_win = sat_inc(slp_win);
        if (window_closes(slp_win, 1'b0)) begin
          done_flags[EN_SLEEP] = 1'b1;
          if (base_lo > success_thr)      sleep_code = SC_BASE_LOW;
          else if (base_hi < half_thr)    sleep_code = SC_NONE;
          else if (base_hi > success_thr) sleep_code = SC_BASE_HIGH;
          if (tip_lo > success_thr)       sleep_code |= SC_TOOL_LOW;
          else if (tip_hi < half_thr)     sleep_code |= SC_NONE;
          else if (tip_hi > success_thr)  sleep_code |= SC_TOOL_HIGH;
          case (sleep_code)
            SC_ERROR:                  dec_sleep = SLEEP_ERROR;
            SC_BASE_HIGH, SC_BASE_TLOW: dec_sleep = SLEEP_IN_BASE;
            SC_TOOL_HIGH, SC_SLP_BLOW:  dec_sleep = SLEEP_ASLEEP;
            SC_WORKING:                dec_sleep = SLEEP_WORKING;
            default:                   ;
          endcase
          {base_lo, base_hi, tip_lo, tip_hi, slp_win} = '0;
        end
      end
    end
    d.tool_present = dec_present;
    d.first_type   = dec_first;
    d.second_type  = dec_second;
    d.sleep_status = dec_sleep;
    d.done_flags   = done_flags;
    return d;
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : channel_monitor
    decision_t seen;
    decision_t want;
    in_item_t  beat;
    if (!rst_ni) begin
      window_len  = WINDOW_LENGTH_RST;
      success_thr = SUCCESS_COUNT_RST;
      fail_thr    = FAIL_COUNT_RST;
      half_thr    = HALF_COUNT_RST;
      t2_mode     = T2_MODE_BAND;
      clear_qualifiers();
      sleep_code  = SC_ERROR;
      expected_decisions.delete();
      mismatch_total = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Result beats are checked first: a beat accepted at this edge cannot answer yet.
      if (out_valid_i && out_ready_i) begin
        seen = '{tool_present_i, first_type_i, second_type_i, sleep_status_i,
                 window_done_flags_i};
        if (expected_decisions.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_MAX)
            $display("%0t: result beat with no input beat waiting: %p", $realtime, seen);
        end else begin
          want = expected_decisions.pop_front();
          if (seen !== want) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_MAX) begin
              $display("%0t: result mismatch", $realtime);
              $display("  tool_present exp %0d got %0d", want.tool_present, seen.tool_present);
              $display("  first_type   exp %0d got %0d", want.first_type, seen.first_type);
              $display("  second_type  exp %0d got %0d", want.second_type, seen.second_type);
              $display("  sleep_status exp %0d got %0d", want.sleep_status, seen.sleep_status);
              $display("  done_flags   exp %b got %b", want.done_flags, seen.done_flags);
            end
          end
        end
      end

      // Configuration writes; unused indexes are ignored.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WINDOW_LENGTH: window_len  = cfg_data_i;
          CFG_SUCCESS_COUNT: success_thr = cfg_data_i;
          CFG_FAIL_COUNT:    fail_thr    = cfg_data_i;
          CFG_HALF_COUNT:    half_thr    = cfg_data_i;
          CFG_TYPE2_MODE:    t2_mode     = cfg_data_i[MODE_W-1:0];
          default:           ;
        endcase
      end

      // Every accepted input beat yields exactly one result beat.
      if (in_valid_i && in_ready_i) begin
        beat = '{req_type: req_type_i, check_enables: check_enables_i, heating: heating_i,
                 presence_pin: presence_pin_i, type1_pin: type1_pin_i,
                 type2_pin: type2_pin_i, handle_pin: handle_pin_i,
                 tip_pin: tip_pin_i};
        expected_decisions.push_back(predict_decisions(beat));
      end

      pending_o    <= expected_decisions.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

FILE: dv/tb_tool_and_sleep_window_qualifier.sv
// Testbench top for the tool and sleep window qualifier: stimulus, back pressure and verdict.
`timescale 1ns / 1ps
module tb_tool_and_sleep_window_qualifier;
  import tswq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 80;
  // Index with no register behind it, and the type 2 mode code that acts as off.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = '1;
  localparam logic [MODE_W-1:0]    T2_MODE_SPARE = '1;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_valid_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i      = '0;
  logic [CFG_W-1:0]     cfg_data_i       = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 req_type_i       = REQ_SAMPLE;
  logic [NUM_QUAL-1:0]  check_enables_i  = '0;
  logic                 heating_i        = 1'b0;
  logic                 presence_pin_i   = 1'b0;
  logic                 type1_pin_i      = 1'b0;
  logic                 type2_pin_i      = 1'b0;
  logic                 handle_pin_i     = 1'b0;
  logic                 tip_pin_i        = 1'b0;
  logic                 out_ready_i      = 1'b0;

  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 tool_present_o;
  logic [1:0]           first_type_o;
  logic [1:0]           second_type_o;
  logic [1:0]           sleep_status_o;
  logic [NUM_QUAL-1:0]  window_done_flags_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count    = 0;
  logic        src_idle_en    = 1'b0;
  logic        sink_idle_en   = 1'b0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;

  tool_and_sleep_window_qualifier DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .req_type_i          (req_type_i),
    .check_enables_i     (check_enables_i),
    .heating_i           (heating_i),
    .presence_pin_i      (presence_pin_i),
    .type1_pin_i         (type1_pin_i),
    .type2_pin_i         (type2_pin_i),
    .handle_pin_i        (handle_pin_i),
    .tip_pin_i           (tip_pin_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .tool_present_o      (tool_present_o),
    .first_type_o        (first_type_o),
    .second_type_o       (second_type_o),
    .sleep_status_o      (sleep_status_o),
    .window_done_flags_o (window_done_flags_o)
  );

  tswq_decision_checker decision_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .req_type_i          (req_type_i),
    .check_enables_i     (check_enables_i),
    .heating_i           (heating_i),
    .presence_pin_i      (presence_pin_i),
    .type1_pin_i         (type1_pin_i),
    .type2_pin_i         (type2_pin_i),
    .handle_pin_i        (handle_pin_i),
    .tip_pin_i           (tip_pin_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .tool_present_i      (tool_present_o),
    .first_type_i        (first_type_o),
    .second_type_i       (second_type_o),
    .sleep_status_i      (sleep_status_o),
    .window_done_flags_i (window_done_flags_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stall bursts, and one long hold-off that backs up the block.
  always begin : result_sink
    if (long_hold_req && !long_hold_done) begin
      out_ready_i <= 1'b0;
      long_hold_done <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk_i);
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
    @(posedge clk_i);
  end

  function automatic in_item_t make_beat(logic req, logic [NUM_QUAL-1:0] en, logic heat,
                                         logic [4:0] pins);
    in_item_t beat;
    beat.req_type       = req;
    beat.check_enables  = en;
    beat.heating        = heat;
    {beat.presence_pin, beat.type1_pin, beat.type2_pin, beat.handle_pin,
     beat.tip_pin} = pins;
    return beat;
  endfunction

  // Offers one beat, after an optional idle burst, and returns at its acceptance edge.
  task automatic send_beat(input in_item_t beat);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= beat.req_type;
    check_enables_i <= beat.check_enables;
    heating_i       <= beat.heating;
    presence_pin_i  <= beat.presence_pin;
    type1_pin_i     <= beat.type1_pin;
    type2_pin_i     <= beat.type2_pin;
    handle_pin_i    <= beat.handle_pin;
    tip_pin_i       <= beat.tip_pin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering and waits until every result beat has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Leaves cfg_valid_i high so that back-to-back writes need no toggling.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] succ,
                                input logic [CFG_W-1:0] fl, input logic [CFG_W-1:0] half,
                                input logic [MODE_W-1:0] mode);
    logic [CFG_W-MODE_W-1:0] junk;
    junk = (CFG_W-MODE_W)'($urandom);
    write_reg(CFG_WINDOW_LENGTH, win);
    write_reg(CFG_SUCCESS_COUNT, succ);
    write_reg(CFG_FAIL_COUNT, fl);
    write_reg(CFG_HALF_COUNT, half);
    // Upper data bits of the mode write must be dropped by the block.
    write_reg(CFG_TYPE2_MODE, {junk, mode});
    write_reg(CFG_SPARE, CFG_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Random samples in segments of steady pin bias, so windows see firm levels;
  // in noisy mode some clears, enable changes and heating are mixed in.
  task automatic run_phase(input int unsigned n_items, input int unsigned seg_max,
                           input logic noisy);
    in_item_t            beat;
    int unsigned         seg_left;
    int unsigned         bias [5];
    logic [NUM_QUAL-1:0] en;
    seg_left = 0;
    en = '1;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, seg_max);
        foreach (bias[p]) bias[p] = $urandom_range(0, 4);
        en = (noisy && $urandom_range(0, 3) == 0) ? NUM_QUAL'($urandom) : '1;
      end
      seg_left--;
      beat = make_beat(REQ_SAMPLE, en, noisy && $urandom_range(0, 11) == 0,
                       {$urandom_range(0, 3) < bias[0], $urandom_range(0, 3) < bias[1],
                        $urandom_range(0, 3) < bias[2], $urandom_range(0, 3) < bias[3],
                        $urandom_range(0, 3) < bias[4]});
      if (noisy) begin
        case ($urandom_range(0, 49))
          0:       beat.req_type = REQ_CLEAR;
          1:       beat.check_enables = NUM_QUAL'($urandom);
          default: ;
        endcase
      end
      send_beat(beat);
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] w;
    repeat (9) @(posedge clk_i);
    rst_ni       <= 1'b1;
    src_idle_en  <= 1'b1;
    sink_idle_en <= 1'b1;
    @(posedge clk_i);

    // Directed: clear, a low window, disable under heating, a frozen beat,
    // a high window and a final clear, all on reset settings.
    send_beat(make_beat(REQ_CLEAR, '1, 1'b1, '1));
    repeat (12) send_beat(make_beat(REQ_SAMPLE, '1, 1'b0, '0));
    send_beat(make_beat(REQ_SAMPLE, '0, 1'b1, '1));
    send_beat(make_beat(REQ_SAMPLE, '1, 1'b1, '1));
    repeat (10) send_beat(make_beat(REQ_SAMPLE, '1, 1'b0, '1));
    send_beat(make_beat(REQ_CLEAR, '0, 1'b0, '0));

    // A window length of one with zero thresholds.
    drain();
    apply_settings(10'd1, '0, '0, '0, T2_MODE_OFF);
    run_phase(100, 6, 1'b1);

    // Reset settings, with the result side held off once while beats keep coming.
    drain();
    apply_settings(WINDOW_LENGTH_RST, SUCCESS_COUNT_RST, FAIL_COUNT_RST, HALF_COUNT_RST,
                   T2_MODE_BAND);
    src_idle_en   <= 1'b0;
    long_hold_req <= 1'b1;
    run_phase(150, 30, 1'b1);
    src_idle_en   <= 1'b1;
    long_hold_req <= 1'b0;

    drain();
    apply_settings(10'd6, 10'd4, 10'd1, 10'd3, T2_MODE_LOW);
    run_phase(120, 20, 1'b1);

    drain();
    apply_settings(10'd16, 10'd12, 10'd3, 10'd8, T2_MODE_SPARE);
    run_phase(120, 40, 1'b1);

    // Threshold extremes.
    drain();
    apply_settings(10'd5, '1, '1, '0, T2_MODE_BAND);
    run_phase(100, 20, 1'b1);

    repeat (3) begin
      drain();
      w = CFG_W'($urandom_range(1, 24));
      apply_settings(w, CFG_W'($urandom_range(0, w + 4)), CFG_W'($urandom_range(0, w + 2)),
                     CFG_W'($urandom_range(0, w + 2)), MODE_W'($urandom));
      run_phase(100, 25, 1'b1);
    end

    // A long window, so the counts grow to several hundred.
    drain();
    apply_settings(10'd400, 10'd200, 10'd40, 10'd280, T2_MODE_LOW);
    run_phase(420, 200, 1'b0);

    // Last stretch at full rate on both sides.
    drain();
    src_idle_en  <= 1'b0;
    sink_idle_en <= 1'b0;
    w = CFG_W'($urandom_range(1, 16));
    apply_settings(w, CFG_W'($urandom_range(0, w)), CFG_W'($urandom_range(0, w)),
                   CFG_W'($urandom_range(0, w)), T2_MODE_BAND);
    run_phase(100, 25, 1'b1);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/tswq_pkg.sv
sv/tool_and_sleep_window_qualifier.sv
dv/tswq_decision_checker.sv
dv/tb_tool_and_sleep_window_qualifier.sv
